/* hw/rtl/aea_pkg.sv */
// Shared types, widths and constants for the ADSR envelope applier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package aea_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEN_W       = 16;
  localparam int NOTE_W      = 24;
  localparam int NUM_W       = 25;
  localparam int DEN_W       = 24;
  localparam int PHASE_W     = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int POSITION_BITS_DEFAULT      = 24;
  localparam int GAIN_FRACTION_BITS_DEFAULT = 16;

  localparam logic [LEN_W-1:0]  ATTACK_RESET  = 16'd4410;
  localparam logic [LEN_W-1:0]  DECAY_RESET   = 16'd4410;
  localparam logic [LEN_W-1:0]  RELEASE_RESET = 16'd4410;
  localparam logic [NOTE_W-1:0] NOTE_RESET    = 24'd44100;

  // The attack peak of 1.2 is the ratio of these two factors.
  localparam int PEAK_NUM = 6;
  localparam int PEAK_DEN = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTE    = 3'd3;

  typedef enum logic [PHASE_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_RISE    = 3'd4,
    PH_FALL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_MUL
  } state_t;

endpackage

/* hw/rtl/aea_divider.sv */
// Restoring divider that forms the envelope gain num * 2^F / den, one quotient bit a cycle.
// Depends on aea_pkg; the operands must satisfy num <= 2 * den.
`timescale 1ns / 1ps

module aea_divider #(
  parameter int GAIN_FRACTION_BITS = aea_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [aea_pkg::NUM_W-1:0]     num,
  input  logic [aea_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [GAIN_FRACTION_BITS+1:0] quot
);
  import aea_pkg::*;

  localparam int STEPS = GAIN_FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [STEPS-1:0] dsr;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem, dsr[STEPS-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(num[NUM_W-1:2]);
      dsr   <= {num[1:0], {GAIN_FRACTION_BITS{1'b0}}};
      den_r <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dsr  <= dsr << 1;
      quot <= {quot[STEPS-2:0], fits};
    end
  end

endmodule

/* hw/rtl/aea_scaler.sv */
// Multiplies a sample by the gain, then truncates toward zero and saturates to 16 bits.
// Depends on aea_pkg; the product is registered before the shift and saturation.
`timescale 1ns / 1ps

module aea_scaler #(
  parameter int GAIN_FRACTION_BITS = aea_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [aea_pkg::SAMPLE_W-1:0] sample,
  input  logic [GAIN_FRACTION_BITS+1:0]       gain,
  output logic signed [aea_pkg::SAMPLE_W-1:0] result
);
  import aea_pkg::*;

  localparam int MAG_W   = SAMPLE_W + 1;
  localparam int GAIN_W  = GAIN_FRACTION_BITS + 2;
  localparam int PROD_W  = MAG_W + GAIN_W;
  localparam int SHIFT_W = PROD_W - GAIN_FRACTION_BITS;

  localparam logic [SHIFT_W-1:0] POS_LIMIT = SHIFT_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [SHIFT_W-1:0] NEG_LIMIT = SHIFT_W'(1 << (SAMPLE_W - 1));

  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic               neg;
  logic [SHIFT_W-1:0] shifted;
  logic [SAMPLE_W-1:0] low_bits;

  assign mag = sample[SAMPLE_W-1] ? MAG_W'(-{sample[SAMPLE_W-1], sample})
                                  : MAG_W'({1'b0, sample});

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(mag) * PROD_W'(gain);
      neg  <= sample[SAMPLE_W-1];
    end
  end

  assign shifted  = prod[PROD_W-1:GAIN_FRACTION_BITS];
  assign low_bits = shifted[SAMPLE_W-1:0];

  always_comb begin
    if (neg) begin
      result = (shifted > NEG_LIMIT) ? signed'(NEG_LIMIT[SAMPLE_W-1:0])
                                     : signed'(~low_bits + SAMPLE_W'(1));
    end else begin
      result = (shifted > POS_LIMIT) ? signed'(POS_LIMIT[SAMPLE_W-1:0]) : signed'(low_bits);
    end
  end

endmodule

/* hw/rtl/adsr_envelope_applier.sv */
// ADSR envelope applier: scales each item by a piecewise-linear gain set by its note position.
// One item at a time: the next item is taken only after the current one has passed the bit-serial
// gain divider and the scaler and its result has been written to the output; a waiting result
// does not block the next acceptance.
// Synchronous reset loads the default lengths, clears the position counter and empties the output.
`timescale 1ns / 1ps

module adsr_envelope_applier #(
  parameter int POSITION_BITS      = aea_pkg::POSITION_BITS_DEFAULT,
  parameter int GAIN_FRACTION_BITS = aea_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [aea_pkg::SAMPLE_W-1:0]    sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [aea_pkg::SAMPLE_W-1:0]    sample_out,
  output logic [aea_pkg::PHASE_W-1:0]            envelope_phase,
  output logic                                   note_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [aea_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [aea_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import aea_pkg::*;

  localparam int CMP_W  = (POSITION_BITS > NOTE_W) ? POSITION_BITS : NOTE_W;
  localparam int LSUM_W = LEN_W + 2;
  localparam int GAIN_W = GAIN_FRACTION_BITS + 2;

  state_t state, state_next;

  logic [LEN_W-1:0]         attack_length;
  logic [LEN_W-1:0]         decay_length;
  logic [LEN_W-1:0]         release_length;
  logic [NOTE_W-1:0]        note_length;
  logic [POSITION_BITS-1:0] sample_position;
  logic signed [SAMPLE_W-1:0] sample_r;
  phase_t                   phase_r;
  logic                     last_r;

  logic [NOTE_W-1:0] n_eff;
  logic [NOTE_W-1:0] n_m1;
  logic [CMP_W-1:0]  p_ext;
  logic              last;
  logic [NOTE_W-1:0] p_clamp;
  logic [NOTE_W-1:0] half;
  logic [LSUM_W-1:0] len_sum;
  logic [LEN_W:0]    ad_sum;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  phase_t            phase;

  logic              div_start;
  logic              div_done;
  logic [GAIN_W-1:0] gain;
  logic              mul_load;
  logic              out_write;
  logic              out_free;
  logic signed [SAMPLE_W-1:0] scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_length  <= ATTACK_RESET;
      decay_length   <= DECAY_RESET;
      release_length <= RELEASE_RESET;
      note_length    <= NOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_length  <= cfg_data[LEN_W-1:0];
        REG_DECAY:   decay_length   <= cfg_data[LEN_W-1:0];
        REG_RELEASE: release_length <= cfg_data[LEN_W-1:0];
        REG_NOTE:    note_length    <= cfg_data[NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff   = (note_length == '0) ? NOTE_W'(1) : note_length;
    n_m1    = n_eff - NOTE_W'(1);
    p_ext   = CMP_W'(sample_position);
    last    = p_ext >= CMP_W'(n_m1);
    p_clamp = last ? n_m1 : p_ext[NOTE_W-1:0];
    half    = n_eff >> 1;
    len_sum = LSUM_W'(attack_length) + LSUM_W'(decay_length) + LSUM_W'(release_length);
    ad_sum  = (LEN_W + 1)'(attack_length) + (LEN_W + 1)'(decay_length);
    num     = NUM_W'(1);
    den     = DEN_W'(1);
    phase   = PH_SUSTAIN;
    if (n_eff < NOTE_W'(len_sum)) begin
      if (p_clamp < half) begin
        phase = PH_RISE;
        num   = NUM_W'(p_clamp);
        den   = half;
      end else begin
        phase = PH_FALL;
        num   = {n_eff - p_clamp, 1'b0};
        den   = n_eff;
      end
    end else if (p_clamp < NOTE_W'(attack_length)) begin
      phase = PH_ATTACK;
      num   = NUM_W'(p_clamp) * NUM_W'(PEAK_NUM);
      den   = DEN_W'(attack_length) * DEN_W'(PEAK_DEN);
    end else if (p_clamp < NOTE_W'(ad_sum)) begin
      phase = PH_DECAY;
      num   = NUM_W'(decay_length) * NUM_W'(PEAK_NUM)
            - (NUM_W'(p_clamp) - NUM_W'(attack_length));
      den   = DEN_W'(decay_length) * DEN_W'(PEAK_DEN);
    end else if (p_clamp >= n_eff - NOTE_W'(release_length)) begin
      phase = PH_RELEASE;
      num   = NUM_W'(n_eff - p_clamp);
      den   = DEN_W'(release_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    mul_load   = 1'b0;
    out_write  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          mul_load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (out_free) begin
          out_write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
    end else if (div_start) begin
      sample_position <= last ? '0 : sample_position + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample_r <= sample_in;
    end
    if (div_start) begin
      phase_r <= phase;
      last_r  <= last;
    end
  end

  aea_divider #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_divider (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (gain)
  );

  aea_scaler #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_scaler (
    .clk   (clk),
    .load  (mul_load),
    .sample(sample_r),
    .gain  (gain),
    .result(scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      sample_out     <= scaled;
      envelope_phase <= phase_r;
      note_end       <= last_r;
    end
  end

endmodule
